FILE: src/http_request_header_parser_unit_macros.svh
// Assertion macros for the HTTP request header parser unit.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef HTTP_REQUEST_HEADER_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define HRHP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrhp: same-cycle check failed");
`define HRHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrhp: next-cycle check failed");
`else
`define HRHP_ASSERT_SAME(label, clk, rst, ante, cons)
`define HRHP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/hrhp_pkg.sv
// Shared types, constants and prefix tables for the HTTP request header parser.
// No dependencies; every other file but the macros header imports this package.
package hrhp_pkg;

  localparam int LENGTH_WIDTH = 32;
  localparam int ACC_WIDE     = LENGTH_WIDTH + 4;
  localparam int COL_WIDTH    = 5;
  localparam int NUM_PREFIX   = 3;
  localparam int TEXT_BYTES   = 32;

  localparam logic [COL_WIDTH-1:0] COL_MAX = '1;

  typedef enum logic [1:0] {
    PH_REQ_LINE = 2'd0,
    PH_HEADERS  = 2'd1,
    PH_BODY     = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    TAG_NONE   = 3'd0,
    TAG_METHOD = 3'd1,
    TAG_PATH   = 3'd2,
    TAG_PROTO  = 3'd3,
    TAG_CTYPE  = 3'd4,
    TAG_REQID  = 3'd5,
    TAG_BODY   = 3'd6,
    TAG_LENGTH = 3'd7
  } tag_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] SLOT_CL = 2'd0;
  localparam logic [1:0] SLOT_CT = 2'd1;
  localparam logic [1:0] SLOT_ID = 2'd2;

  // Prefix texts padded with NUL bytes to a full line of columns. A NUL never
  // reaches the prefix compare, so the padding also acts as the length check.
  localparam logic [8*TEXT_BYTES-1:0] CL_TEXT = {"Content-Length: ", {16{8'h00}}};
  localparam logic [8*TEXT_BYTES-1:0] CT_TEXT = {"content-type: ", {18{8'h00}}};
  localparam logic [8*TEXT_BYTES-1:0] ID_TEXT = {"___internal-request-id: ", {8{8'h00}}};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } req_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  field_tag;
    logic        field_first;
    logic [31:0] length_value;
    logic        headers_done;
    logic        message_end;
  } res_item_t;

  function automatic logic [7:0] prefix_byte(logic [1:0] slot, logic [COL_WIDTH-1:0] col);
    logic [8*TEXT_BYTES-1:0] text;
    case (slot)
      SLOT_CL: text = CL_TEXT;
      SLOT_CT: text = CT_TEXT;
      default: text = ID_TEXT;
    endcase
    return text[8*(TEXT_BYTES-1-int'(col)) +: 8];
  endfunction

  function automatic logic [COL_WIDTH-1:0] prefix_last(logic [1:0] slot);
    logic [COL_WIDTH-1:0] col;
    case (slot)
      SLOT_CL: col = COL_WIDTH'(15);
      SLOT_CT: col = COL_WIDTH'(13);
      default: col = COL_WIDTH'(23);
    endcase
    return col;
  endfunction

  function automatic tag_t prefix_tag(logic [1:0] slot);
    tag_t tag;
    case (slot)
      SLOT_CL: tag = TAG_LENGTH;
      SLOT_CT: tag = TAG_CTYPE;
      default: tag = TAG_REQID;
    endcase
    return tag;
  endfunction

endpackage

FILE: src/hrhp_if.sv
// Valid/ready stream interfaces for request bytes and tagged result beats.
// Depends on hrhp_pkg.
interface hrhp_req_if import hrhp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface hrhp_res_if import hrhp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  field_tag;
  logic        field_first;
  logic [31:0] length_value;
  logic        headers_done;
  logic        message_end;

  modport source (output valid, output out_byte, output field_tag, output field_first,
                  output length_value, output headers_done, output message_end,
                  input ready);
  modport sink   (input valid, input out_byte, input field_tag, input field_first,
                  input length_value, input headers_done, input message_end,
                  output ready);
endinterface

FILE: src/http_request_header_parser_unit.sv
// HTTP request header parser unit, top level.
// The req channel takes one byte of an HTTP request per beat, with last on the
// final byte. The res channel returns one beat per request byte: the byte, its
// field tag, a first-byte flag, the Content-Length parsed so far, a flag that
// the blank line ending the headers has passed, and a message end flag.
// A byte is held in the input register, tagged by the parser logic, and stored
// in the result register; a stall on res can hold it in the input register.
// Throughput is one byte per cycle while res does not stall; the parser state
// update is the single per-byte step.
// When res stalls, the result register holds its beat and the input register
// keeps taking one more byte; req.ready drops only when both are full.
// Reset (rst, synchronous) empties both registers and returns the parser to the
// start of a request line; a NUL byte or the last flag returns the parser there
// after the byte is tagged, but leaves both registers as they are.
// Depends on hrhp_pkg, hrhp_if and the macros header.
`include "http_request_header_parser_unit_macros.svh"

module http_request_header_parser_unit import hrhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hrhp_req_if.sink   req,
  hrhp_res_if.source res
);

  logic      item_valid;
  req_item_t item;
  logic      can_load;
  logic      fire;
  res_item_t result;

  assign fire = item_valid && can_load;

  hrhp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (fire)
  );

  hrhp_tagger u_tagger (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  hrhp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .result   (result),
    .can_load (can_load),
    .res      (res)
  );

  `HRHP_ASSERT_NEXT(a_fire_gives_beat, clk, rst, fire, res.valid)
  `HRHP_ASSERT_NEXT(a_nul_ends_message, clk, rst, fire && (item.data_byte == CH_NUL), res.message_end)
  `HRHP_ASSERT_SAME(a_first_has_tag, clk, rst, res.valid && res.field_first, res.field_tag != TAG_NONE)

endmodule

FILE: src/hrhp_in_reg.sv
// Input register: captures one request byte beat and holds it until the tagger takes it.
// Depends on hrhp_pkg and hrhp_req_if.
module hrhp_in_reg import hrhp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  hrhp_req_if.sink  req,
  output logic      item_valid,
  output req_item_t item,
  input  logic      item_take
);

  assign req.ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.data_byte <= req.data_byte;
      item.last      <= req.last;
    end
  end

endmodule

FILE: src/hrhp_tagger.sv
// Parser state and per-byte tagging logic: request line split, header prefix
// match, Content-Length accumulation and body tagging. Depends on hrhp_pkg.
module hrhp_tagger import hrhp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  req_item_t item,
  output res_item_t result
);

  phase_t                  phase, phase_next;
  logic [1:0]              token_index, token_index_next;
  logic [COL_WIDTH-1:0]    column, column_next;
  logic [NUM_PREFIX-1:0]   prefix_alive, prefix_alive_next;
  tag_t                    value_tag, value_tag_next;
  logic [LENGTH_WIDTH-1:0] length_accum, length_accum_next;
  logic                    length_stopped, length_stopped_next;
  logic                    line_only_cr, line_only_cr_next;

  logic [7:0]              b;
  logic                    msg_end;
  logic [COL_WIDTH-1:0]    col_inc;
  logic                    is_digit;
  logic [3:0]              digit;
  logic [ACC_WIDE-1:0]     acc_ext;
  logic [ACC_WIDE-1:0]     acc_sum;
  logic [LENGTH_WIDTH-1:0] acc_step;
  logic                    hit_valid;
  logic [1:0]              hit_slot;

  assign b        = item.data_byte;
  assign msg_end  = item.last || (b == CH_NUL);
  assign col_inc  = (column == COL_MAX) ? column : column + 1'b1;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit    = 4'(b - CH_ZERO);

  // accum * 10 + digit; any bit above the length width means saturation.
  assign acc_ext  = ACC_WIDE'(length_accum);
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + ACC_WIDE'(digit);
  assign acc_step = (|acc_sum[ACC_WIDE-1:LENGTH_WIDTH]) ? '1 : acc_sum[LENGTH_WIDTH-1:0];

  // Next state for one accepted byte.
  always_comb begin
    phase_next          = phase;
    token_index_next    = token_index;
    column_next         = column;
    prefix_alive_next   = prefix_alive;
    value_tag_next      = value_tag;
    length_accum_next   = length_accum;
    length_stopped_next = length_stopped;
    line_only_cr_next   = line_only_cr;
    hit_valid           = 1'b0;
    hit_slot            = SLOT_CL;

    if (b != CH_NUL) begin
      unique case (phase)
        PH_REQ_LINE: begin
          if (b == CH_LF) begin
            phase_next        = PH_HEADERS;
            column_next       = '0;
            prefix_alive_next = '1;
            value_tag_next    = TAG_NONE;
            line_only_cr_next = 1'b0;
          end else if (b == CH_SPACE) begin
            if (token_index != 2'd3) begin
              token_index_next = token_index + 2'd1;
            end
            column_next = '0;
          end else if (token_index != 2'd3) begin
            column_next = col_inc;
          end
        end
        PH_HEADERS: begin
          if (b == CH_LF) begin
            if (line_only_cr) begin
              phase_next  = PH_BODY;
              column_next = '0;
            end else begin
              column_next       = '0;
              prefix_alive_next = '1;
              value_tag_next    = TAG_NONE;
              line_only_cr_next = 1'b0;
            end
          end else if (value_tag == TAG_NONE) begin
            line_only_cr_next = (column == '0) && (b == CH_CR);
            for (int k = 0; k < NUM_PREFIX; k++) begin
              if (prefix_alive[k]) begin
                if (b == prefix_byte(2'(k), column)) begin
                  if (column == prefix_last(2'(k))) begin
                    hit_valid = 1'b1;
                    hit_slot  = 2'(k);
                  end
                end else begin
                  prefix_alive_next[k] = 1'b0;
                end
              end
            end
            if (hit_valid) begin
              value_tag_next = prefix_tag(hit_slot);
              column_next    = '0;
              if (prefix_tag(hit_slot) == TAG_LENGTH) begin
                length_accum_next   = '0;
                length_stopped_next = 1'b0;
              end
            end else begin
              column_next = col_inc;
            end
          end else if (value_tag == TAG_LENGTH) begin
            line_only_cr_next = 1'b0;
            if (!length_stopped) begin
              if (is_digit) begin
                length_accum_next = acc_step;
              end else begin
                length_stopped_next = 1'b1;
              end
            end
          end else begin
            line_only_cr_next = 1'b0;
            column_next       = col_inc;
          end
        end
        default: begin
          column_next = COL_WIDTH'(1);
        end
      endcase
    end
  end

  // Result fields for the same byte.
  always_comb begin
    result.out_byte     = b;
    result.field_tag    = TAG_NONE;
    result.field_first  = 1'b0;
    result.length_value = 32'(length_accum_next);
    result.headers_done = (phase_next != PH_REQ_LINE) && (phase_next != PH_HEADERS);
    result.message_end  = msg_end;

    if (b != CH_NUL) begin
      unique case (phase)
        PH_REQ_LINE: begin
          if (b != CH_LF && b != CH_SPACE && token_index != 2'd3) begin
            result.field_tag   = 3'({1'b0, token_index}) + 3'd1;
            result.field_first = (column == '0);
          end
        end
        PH_HEADERS: begin
          if (b != CH_LF && value_tag != TAG_NONE && value_tag != TAG_LENGTH) begin
            result.field_tag   = value_tag;
            result.field_first = (column == '0);
          end
        end
        default: begin
          result.field_tag   = TAG_BODY;
          result.field_first = (column == '0);
        end
      endcase
    end
  end

  // The message end returns every state element to its reset value.
  always_ff @(posedge clk) begin
    if (rst || (fire && msg_end)) begin
      phase          <= PH_REQ_LINE;
      token_index    <= '0;
      column         <= '0;
      prefix_alive   <= '1;
      value_tag      <= TAG_NONE;
      length_accum   <= '0;
      length_stopped <= 1'b0;
      line_only_cr   <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      token_index    <= token_index_next;
      column         <= column_next;
      prefix_alive   <= prefix_alive_next;
      value_tag      <= value_tag_next;
      length_accum   <= length_accum_next;
      length_stopped <= length_stopped_next;
      line_only_cr   <= line_only_cr_next;
    end
  end

endmodule

FILE: src/hrhp_out_reg.sv
// Result register: holds one tagged beat until the sink takes it.
// Depends on hrhp_pkg and hrhp_res_if.
module hrhp_out_reg import hrhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_item_t  result,
  output logic       can_load,
  hrhp_res_if.source res
);

  logic      out_valid;
  res_item_t out_item;

  assign can_load = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_item <= result;
    end
  end

  assign res.valid        = out_valid;
  assign res.out_byte     = out_item.out_byte;
  assign res.field_tag    = out_item.field_tag;
  assign res.field_first  = out_item.field_first;
  assign res.length_value = out_item.length_value;
  assign res.headers_done = out_item.headers_done;
  assign res.message_end  = out_item.message_end;

endmodule
